// ----- rtl/sks_pkg.sv -----
// sks_pkg: sizes, codes and shared types for the sorted key slot table
// used by every module of the block except sks_ram; depends on nothing
`default_nettype none

package sks_pkg;

	localparam int TABLE_DEPTH = 256;
	localparam int KEY_BITS    = 32;
	localparam int VALUE_BITS  = 16;
	localparam int SLOT_W      = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = SLOT_W + 1;

	typedef logic [KEY_BITS-1:0]   key_t;
	typedef logic [VALUE_BITS-1:0] value_t;
	typedef logic [SLOT_W-1:0]     slot_t;
	typedef logic [CNT_W-1:0]      count_t;

	typedef enum logic [2:0] {
		MODE_LOOKUP = 3'd0,
		MODE_ADD    = 3'd1,
		MODE_DEACT  = 3'd2,
		MODE_CLEAR  = 3'd3,
		MODE_FETCH  = 3'd4
	} mode_t;

	typedef enum logic [2:0] {
		ST_HIT       = 3'd0,
		ST_ADDED     = 3'd1,
		ST_NOT_FOUND = 3'd2,
		ST_FULL      = 3'd3,
		ST_BAD_SLOT  = 3'd4,
		ST_INACTIVE  = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DISPATCH,
		S_SCAN,
		S_APPLY,
		S_READ,
		S_RESP
	} state_t;

	// strobes broadcast to every cell of the row
	typedef struct packed {
		logic cmp;
		logic ins;
		logic clr;
	} cell_cmd_t;

	typedef struct packed {
		logic  valid;
		key_t  key;
		slot_t slot;
	} entry_t;

	// match report walking down the row
	typedef struct packed {
		logic  hit;
		slot_t slot;
	} probe_t;

endpackage

`default_nettype wire

// ----- rtl/sks_ram.sv -----
// sks_ram: generic single write port, single read port ram, registered read
// stand-alone, no package
`default_nettype none

module sks_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ----- rtl/sks_cell.sv -----
// sks_cell: one position of the sorted key row, with compare, shift-insert
// and match forwarding; depends on sks_pkg
`default_nettype none

module sks_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  sks_pkg::cell_cmd_t cmd,
	input  sks_pkg::key_t      k,
	input  sks_pkg::slot_t     new_slot,
	input  sks_pkg::entry_t    prev_ent,
	input  logic               prev_ge,
	input  sks_pkg::probe_t    probe_in,
	output sks_pkg::entry_t    ent,
	output logic               ge,
	output sks_pkg::probe_t    probe_out
);

	import sks_pkg::*;

	logic   valid_q;
	key_t   key_q;
	slot_t  slot_q;
	logic   eq_q;
	logic   ge_q;
	probe_t probe_q;

	// empty cells count as holding a key above every other
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			eq_q    <= 1'b0;
			ge_q    <= 1'b0;
			probe_q <= '0;
		end else begin
			if (cmd.cmp) begin
				eq_q <= valid_q && (key_q == k);
				ge_q <= !valid_q || (k < key_q);
			end
			if (cmd.clr) begin
				valid_q <= 1'b0;
			end else if (cmd.ins && ge_q) begin
				valid_q <= prev_ge ? prev_ent.valid : 1'b1;
			end
			probe_q <= eq_q ? probe_t'{hit: 1'b1, slot: slot_q} : probe_in;
		end
	end

	// the first cell above the new key (or empty) takes it, the ones after shift up
	always_ff @(posedge clk) begin
		if (cmd.ins && ge_q) begin
			key_q  <= prev_ge ? prev_ent.key : k;
			slot_q <= prev_ge ? prev_ent.slot : new_slot;
		end
	end

	assign ent.valid = valid_q;
	assign ent.key   = key_q;
	assign ent.slot  = slot_q;
	assign ge        = ge_q;
	assign probe_out = probe_q;

endmodule

`default_nettype wire

// ----- rtl/sks_row.sv -----
// sks_row: the chain of TABLE_DEPTH cells holding keys in ascending order
// depends on sks_pkg and sks_cell
`default_nettype none

module sks_row (
	input  logic               clk,
	input  logic               arst_n,
	input  sks_pkg::cell_cmd_t cmd,
	input  sks_pkg::key_t      k,
	input  sks_pkg::slot_t     new_slot,
	output sks_pkg::probe_t    tail
);

	import sks_pkg::*;

	entry_t ent   [TABLE_DEPTH];
	logic   ge    [TABLE_DEPTH];
	probe_t probe [TABLE_DEPTH];

	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		entry_t prev_ent;
		logic   prev_ge;
		probe_t prev_probe;

		if (i == 0) begin : g_head
			assign prev_ent   = '0;
			assign prev_ge    = 1'b0;
			assign prev_probe = '0;
		end else begin : g_link
			assign prev_ent   = ent[i-1];
			assign prev_ge    = ge[i-1];
			assign prev_probe = probe[i-1];
		end

		sks_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cmd       (cmd),
			.k         (k),
			.new_slot  (new_slot),
			.prev_ent  (prev_ent),
			.prev_ge   (prev_ge),
			.probe_in  (prev_probe),
			.ent       (ent[i]),
			.ge        (ge[i]),
			.probe_out (probe[i])
		);
	end

	assign tail = probe[TABLE_DEPTH-1];

endmodule

`default_nettype wire

// ----- rtl/sorted_key_slot_table.sv -----
// lookup and find-or-add wait for the match report to walk the cell row one cell per
// cycle; a lookup hit then reads its value in S_READ, a miss or an add goes to S_RESP
// fetch passes S_DISPATCH, S_READ, S_RESP; deactivate-all, clear, unused modes skip S_READ
// one beat in flight at a time; the next beat is taken the cycle after the output register
// loads, and a finished result may wait in the output register meanwhile
// reset clears the row, the slot active marks and the entry count at once, no clearing pass
`default_nettype none

module sorted_key_slot_table (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_ready,
	input  logic [2:0]  mode,
	input  logic [31:0] key,
	input  logic [15:0] new_value,
	input  logic [7:0]  slot_number,
	output logic        rsp_valid,
	input  logic        rsp_ready,
	output logic [2:0]  status,
	output logic [7:0]  slot,
	output logic [15:0] value
);

	import sks_pkg::*;

	state_t  state_q, state_d;
	logic [2:0] mode_q;
	key_t    k_q;
	value_t  nv_q;
	logic [7:0] sn_q;
	count_t  count_q;
	slot_t   scan_q;
	logic [TABLE_DEPTH-1:0] active_q;

	status_t res_status_q, res_status_d;
	slot_t   res_slot_q, res_slot_d;
	value_t  res_value_q, res_value_d;

	logic    rsp_valid_q;
	status_t out_status_q;
	slot_t   out_slot_q;
	value_t  out_value_q;

	cell_cmd_t cmd;
	probe_t    tail;
	logic      capture, scan_clr, cnt_inc, cnt_clr, act_clr_all, act_set, out_load;
	slot_t     act_idx;
	logic      ram_we;
	slot_t     ram_waddr, ram_raddr;
	value_t    ram_rdata;
	slot_t     sn_idx;
	logic      sn_bad;

	assign sn_idx = sn_q[SLOT_W-1:0];
	assign sn_bad = count_t'(sn_q) >= count_q;

	sks_row u_row (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.k        (k_q),
		.new_slot (count_q[SLOT_W-1:0]),
		.tail     (tail)
	);

	sks_ram #(
		.WIDTH (VALUE_BITS),
		.DEPTH (TABLE_DEPTH)
	) u_values (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (nv_q),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			scan_q      <= '0;
			active_q    <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cnt_clr) begin
				count_q <= '0;
			end else if (cnt_inc) begin
				count_q <= count_q + 1'b1;
			end
			if (scan_clr) begin
				scan_q <= '0;
			end else begin
				scan_q <= scan_q + 1'b1;
			end
			if (act_clr_all) begin
				active_q <= '0;
			end else if (act_set) begin
				active_q[act_idx] <= 1'b1;
			end
			if (out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (capture) begin
			mode_q <= mode;
			k_q    <= key[KEY_BITS-1:0];
			nv_q   <= new_value[VALUE_BITS-1:0];
			sn_q   <= slot_number;
		end
		res_status_q <= res_status_d;
		res_slot_q   <= res_slot_d;
		res_value_q  <= res_value_d;
		if (out_load) begin
			out_status_q <= res_status_q;
			out_slot_q   <= res_slot_q;
			out_value_q  <= res_value_q;
		end
	end

	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		capture      = 1'b0;
		scan_clr     = 1'b0;
		cnt_inc      = 1'b0;
		cnt_clr      = 1'b0;
		act_clr_all  = 1'b0;
		act_set      = 1'b0;
		act_idx      = tail.slot;
		out_load     = 1'b0;
		ram_we       = 1'b0;
		ram_waddr    = tail.slot;
		ram_raddr    = tail.slot;
		res_status_d = res_status_q;
		res_slot_d   = res_slot_q;
		res_value_d  = res_value_q;
		req_ready    = 1'b0;

		case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					capture = 1'b1;
					state_d = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				res_status_d = ST_HIT;
				res_slot_d   = '0;
				res_value_d  = '0;
				ram_raddr    = sn_idx;
				case (mode_t'(mode_q))
					MODE_LOOKUP, MODE_ADD: begin
						cmd.cmp  = 1'b1;
						scan_clr = 1'b1;
						state_d  = S_SCAN;
					end
					MODE_DEACT: begin
						// inactive slots read back as zero, so the values need no sweep
						act_clr_all = 1'b1;
						state_d     = S_RESP;
					end
					MODE_CLEAR: begin
						act_clr_all = 1'b1;
						cnt_clr     = 1'b1;
						cmd.clr     = 1'b1;
						state_d     = S_RESP;
					end
					MODE_FETCH: begin
						state_d = S_READ;
					end
					default: begin
						res_status_d = ST_NOT_FOUND;
						state_d      = S_RESP;
					end
				endcase
			end
			S_SCAN: begin
				// report from the last cell is complete in the following cycle, in S_APPLY
				if (scan_q == slot_t'(TABLE_DEPTH - 1)) begin
					state_d = S_APPLY;
				end
			end
			S_APPLY: begin
				if (tail.hit) begin
					res_status_d = ST_HIT;
					res_slot_d   = tail.slot;
					if (mode_t'(mode_q) == MODE_ADD) begin
						ram_we      = 1'b1;
						act_set     = 1'b1;
						res_value_d = nv_q;
						state_d     = S_RESP;
					end else begin
						state_d = S_READ;
					end
				end else if (mode_t'(mode_q) != MODE_ADD) begin
					res_status_d = ST_NOT_FOUND;
					state_d      = S_RESP;
				end else if (count_q == count_t'(TABLE_DEPTH)) begin
					res_status_d = ST_FULL;
					state_d      = S_RESP;
				end else begin
					cmd.ins      = 1'b1;
					ram_we       = 1'b1;
					ram_waddr    = count_q[SLOT_W-1:0];
					act_set      = 1'b1;
					act_idx      = count_q[SLOT_W-1:0];
					cnt_inc      = 1'b1;
					res_status_d = ST_ADDED;
					res_slot_d   = count_q[SLOT_W-1:0];
					state_d      = S_RESP;
				end
			end
			S_READ: begin
				if (mode_t'(mode_q) == MODE_FETCH) begin
					if (sn_bad) begin
						res_status_d = ST_BAD_SLOT;
					end else if (!active_q[sn_idx]) begin
						res_status_d = ST_INACTIVE;
						res_slot_d   = sn_idx;
					end else begin
						res_status_d = ST_HIT;
						res_slot_d   = sn_idx;
						res_value_d  = ram_rdata;
					end
				end else begin
					res_value_d = active_q[res_slot_q] ? ram_rdata : '0;
				end
				state_d = S_RESP;
			end
			S_RESP: begin
				if (!rsp_valid_q || rsp_ready) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign rsp_valid = rsp_valid_q;
	assign status    = out_status_q;
	assign slot      = 8'(out_slot_q);
	assign value     = 16'(out_value_q);

endmodule

`default_nettype wire

// ----- rtl/sks_checker.sv -----
// sks_checker: port-level checks on the sorted key slot table, bound to the top level
// depends on sks_pkg and sorted_key_slot_table
`default_nettype none

module sks_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	input  logic        req_ready,
	input  logic [2:0]  mode,
	input  logic [31:0] key,
	input  logic [15:0] new_value,
	input  logic [7:0]  slot_number,
	input  logic        rsp_valid,
	input  logic        rsp_ready,
	input  logic [2:0]  status,
	input  logic [7:0]  slot,
	input  logic [15:0] value
);

	import sks_pkg::*;

	a_req_hold: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_ready |=> req_valid && $stable(mode) && $stable(key)
			&& $stable(new_value) && $stable(slot_number))
		else $error("request beat dropped or changed while stalled");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(slot)
			&& $stable(value))
		else $error("result beat dropped or changed while stalled");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> status <= ST_INACTIVE)
		else $error("status code out of range");

	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (status == ST_NOT_FOUND || status == ST_FULL || status == ST_BAD_SLOT)
			|-> slot == 8'd0 && value == 16'd0)
		else $error("miss, full or bad slot result carries slot or value");

	a_zero_value: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (status == ST_ADDED || status == ST_INACTIVE) |-> value == 16'd0)
		else $error("added or inactive result carries a value");

endmodule

bind sorted_key_slot_table sks_checker u_sks_checker (.*);

`default_nettype wire

// ----- verif/tb_sorted_key_slot_table.sv -----
// self-checking bench for sorted_key_slot_table: random and directed beats with a table predictor
// depends on sks_pkg and the sorted_key_slot_table rtl
`default_nettype none

module tb_sorted_key_slot_table;
	import sks_pkg::*;

	localparam int ITEM_TARGET  = 800;
	localparam int QUIET_TAIL   = 60;
	localparam int FILL_AT      = 300;
	localparam int PRESSURE_AT  = 100;
	localparam int LONG_HOLD    = 1000;
	localparam int STALL_LIMIT  = 5000;
	localparam int DRAIN_CYCLES = 2 * TABLE_DEPTH + 20;

	logic        clk;
	logic        arst_n;
	logic        req_valid;
	logic        req_ready;
	logic [2:0]  mode;
	logic [31:0] key;
	logic [15:0] new_value;
	logic [7:0]  slot_number;
	logic        rsp_valid;
	logic        rsp_ready;
	logic [2:0]  status;
	logic [7:0]  slot;
	logic [15:0] value;

	class table_tracker;
		typedef struct {
			status_t st;
			slot_t   sl;
			value_t  val;
		} table_rsp_t;

		key_t        keys_sorted[TABLE_DEPTH];
		slot_t       slot_of[TABLE_DEPTH];
		value_t      slot_val[TABLE_DEPTH];
		bit          slot_on[TABLE_DEPTH];
		int unsigned used;
		int unsigned failures;
		table_rsp_t  pending[$];

		// binary search; on a miss pos is where the key belongs
		function bit find_key(key_t k, output int unsigned pos);
			int unsigned lo, hi, mid;
			lo = 0;
			hi = used;
			while (lo < hi) begin
				mid = (lo + hi) / 2;
				if (k < keys_sorted[mid])
					hi = mid;
				else if (k > keys_sorted[mid])
					lo = mid + 1;
				else begin
					pos = mid;
					return 1'b1;
				end
			end
			pos = lo;
			return 1'b0;
		endfunction

		function void note_request(logic [2:0] m, key_t k, value_t nv, slot_t sn);
			table_rsp_t  r;
			int unsigned pos;
			int unsigned i;
			slot_t       s;
			r.st  = ST_HIT;
			r.sl  = '0;
			r.val = '0;
			case (m)
				MODE_LOOKUP: begin
					if (find_key(k, pos)) begin
						s     = slot_of[pos];
						r.sl  = s;
						r.val = slot_val[s];
					end else
						r.st = ST_NOT_FOUND;
				end
				MODE_ADD: begin
					if (find_key(k, pos)) begin
						s           = slot_of[pos];
						slot_val[s] = nv;
						slot_on[s]  = 1'b1;
						r.sl        = s;
						r.val       = nv;
					end else if (used >= TABLE_DEPTH)
						r.st = ST_FULL;
					else begin
						for (i = used; i > pos; i--) begin
							keys_sorted[i] = keys_sorted[i - 1];
							slot_of[i]     = slot_of[i - 1];
						end
						s                = slot_t'(used);
						keys_sorted[pos] = k;
						slot_of[pos]     = s;
						slot_val[s]      = nv;
						slot_on[s]       = 1'b1;
						used++;
						r.st = ST_ADDED;
						r.sl = s;
					end
				end
				MODE_DEACT: begin
					foreach (slot_on[j]) begin
						slot_on[j]  = 1'b0;
						slot_val[j] = '0;
					end
				end
				MODE_CLEAR: begin
					used = 0;
					foreach (slot_on[j])
						slot_on[j] = 1'b0;
				end
				MODE_FETCH: begin
					if (sn >= used)
						r.st = ST_BAD_SLOT;
					else if (!slot_on[sn]) begin
						r.st = ST_INACTIVE;
						r.sl = sn;
					end else begin
						r.sl  = sn;
						r.val = slot_val[sn];
					end
				end
				default: r.st = ST_NOT_FOUND;
			endcase
			pending.push_back(r);
		endfunction

		function void check_response(logic [2:0] st, logic [7:0] sl, logic [15:0] val);
			table_rsp_t e;
			if (pending.size() == 0) begin
				$error("unexpected response beat: status %0d slot %0d value %0d", st, sl, val);
				failures++;
				return;
			end
			e = pending.pop_front();
			if (st !== e.st) begin
				$error("status: expected %0d, got %0d", e.st, st);
				failures++;
			end
			if (sl !== e.sl) begin
				$error("slot: expected %0d, got %0d", e.sl, sl);
				failures++;
			end
			if (val !== e.val) begin
				$error("value: expected %0h, got %0h", e.val, val);
				failures++;
			end
		endfunction
	endclass

	table_tracker tracker;
	bit           quiet;
	bit           long_hold;
	bit           filled;
	int unsigned  items_sent;
	int unsigned  idle_run;

	sorted_key_slot_table dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_ready   (req_ready),
		.mode        (mode),
		.key         (key),
		.new_value   (new_value),
		.slot_number (slot_number),
		.rsp_valid   (rsp_valid),
		.rsp_ready   (rsp_ready),
		.status      (status),
		.slot        (slot),
		.value       (value)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// sender side: optional gap, then hold the beat until it is taken
	task automatic send_request(logic [2:0] m, key_t k, value_t nv, slot_t sn);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		req_valid   <= 1'b1;
		mode        <= m;
		key         <= k;
		new_value   <= nv;
		slot_number <= sn;
		do @(posedge clk); while (!req_ready);
		tracker.note_request(m, k, nv, sn);
		items_sent++;
	endtask

	function automatic key_t any_key();
		case ($urandom_range(0, 5))
			0: return key_t'($urandom_range(0, 63));
			1: return key_t'(32'hFFFF_FFFF - $urandom_range(0, 3));
			2: begin
				if (tracker.used != 0)
					return tracker.keys_sorted[$urandom_range(0, tracker.used - 1)] + 1;
				return key_t'($urandom);
			end
			3: begin
				if (tracker.used != 0)
					return tracker.keys_sorted[$urandom_range(0, tracker.used - 1)] - 1;
				return key_t'($urandom);
			end
			default: return key_t'($urandom);
		endcase
	endfunction

	function automatic key_t stored_key();
		if (tracker.used == 0)
			return any_key();
		return tracker.keys_sorted[$urandom_range(0, tracker.used - 1)];
	endfunction

	task automatic mixed_item();
		int unsigned pick;
		int unsigned top;
		key_t        k;
		pick = $urandom_range(0, 99);
		if (pick < 40) begin
			k = ($urandom_range(0, 2) == 0) ? stored_key() : any_key();
			send_request(MODE_ADD, k, value_t'($urandom), slot_t'($urandom));
		end else if (pick < 65) begin
			k = ($urandom_range(0, 4) < 3) ? stored_key() : any_key();
			send_request(MODE_LOOKUP, k, value_t'($urandom), slot_t'($urandom));
		end else if (pick < 87) begin
			top = (tracker.used < 253) ? tracker.used + 2 : 255;
			send_request(MODE_FETCH, key_t'($urandom), value_t'($urandom),
				($urandom_range(0, 3) == 0) ? slot_t'($urandom) : slot_t'($urandom_range(0, top)));
		end else if (pick < 91)
			send_request(MODE_DEACT, key_t'($urandom), value_t'($urandom), slot_t'($urandom));
		else if (pick < 93)
			send_request(MODE_CLEAR, key_t'($urandom), value_t'($urandom), slot_t'($urandom));
		else
			send_request(3'($urandom_range(5, 7)), key_t'($urandom), value_t'($urandom),
				slot_t'($urandom));
	endtask

	// fill to the brim, probe the full table, then empty it again
	task automatic fill_table();
		while (tracker.used < TABLE_DEPTH)
			send_request(MODE_ADD, key_t'($urandom), value_t'($urandom), slot_t'($urandom));
		repeat (3)
			send_request(MODE_ADD, key_t'($urandom), value_t'($urandom), slot_t'($urandom));
		send_request(MODE_ADD, stored_key(), value_t'($urandom), slot_t'($urandom));
		send_request(MODE_LOOKUP, stored_key(), value_t'($urandom), slot_t'($urandom));
		send_request(MODE_FETCH, key_t'($urandom), value_t'($urandom), 8'd255);
		send_request(MODE_DEACT, key_t'($urandom), value_t'($urandom), slot_t'($urandom));
		send_request(MODE_FETCH, key_t'($urandom), value_t'($urandom), 8'd200);
		send_request(MODE_ADD, stored_key(), value_t'($urandom), slot_t'($urandom));
		send_request(MODE_CLEAR, key_t'($urandom), value_t'($urandom), slot_t'($urandom));
	endtask

	// receiver side: random stalls, one long hold-off on request, none in the tail
	initial begin
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (long_hold) begin
				rsp_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				long_hold = 1'b0;
			end else if (!quiet && $urandom_range(0, 15) == 0) begin
				rsp_ready <= 1'b0;
				repeat ($urandom_range(1, 15)) @(posedge clk);
			end else
				rsp_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready)
			tracker.check_response(status, slot, value);
	end

	always @(posedge clk) begin
		if (!arst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready))
			idle_run = 0;
		else if (idle_run >= STALL_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end else
			idle_run++;
	end

	initial begin
		tracker     = new;
		arst_n      = 1'b0;
		req_valid   = 1'b0;
		rsp_ready   = 1'b0;
		mode        = MODE_LOOKUP;
		key         = '0;
		new_value   = '0;
		slot_number = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table, extremes of key and value, insert at front and middle
		send_request(MODE_LOOKUP, 32'h0, 16'h0, 8'd0);
		send_request(MODE_FETCH, 32'h0, 16'h0, 8'd0);
		send_request(MODE_ADD, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF);
		send_request(MODE_ADD, 32'h0, 16'h0, 8'd0);
		send_request(MODE_ADD, 32'h8000_0000, 16'h1234, 8'h80);
		send_request(MODE_LOOKUP, 32'h0, 16'h0, 8'd0);
		send_request(MODE_LOOKUP, 32'hFFFF_FFFF, 16'h0, 8'd0);
		send_request(MODE_LOOKUP, 32'h7FFF_FFFF, 16'h0, 8'd0);
		send_request(MODE_ADD, 32'hFFFF_FFFF, 16'h00FF, 8'd0);
		send_request(MODE_FETCH, 32'h0, 16'h0, 8'd0);
		send_request(MODE_FETCH, 32'h0, 16'h0, 8'd2);
		send_request(MODE_FETCH, 32'h0, 16'h0, 8'd3);
		send_request(MODE_FETCH, 32'h0, 16'h0, 8'd255);
		// deactivation keeps keys but drops values and marks
		send_request(MODE_DEACT, 32'h0, 16'h0, 8'd0);
		send_request(MODE_FETCH, 32'h0, 16'h0, 8'd1);
		send_request(MODE_LOOKUP, 32'h8000_0000, 16'h0, 8'd0);
		send_request(MODE_ADD, 32'h8000_0000, 16'hA5A5, 8'd0);
		send_request(MODE_FETCH, 32'h0, 16'h0, 8'd2);
		send_request(3'd5, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF);
		send_request(3'd6, 32'h1, 16'h1, 8'd1);
		send_request(3'd7, 32'h5555_AAAA, 16'h5A5A, 8'h5A);
		send_request(MODE_CLEAR, 32'h0, 16'h0, 8'd0);
		send_request(MODE_LOOKUP, 32'hFFFF_FFFF, 16'h0, 8'd0);
		send_request(MODE_FETCH, 32'h0, 16'h0, 8'd0);

		while (items_sent < ITEM_TARGET) begin
			if (!filled && items_sent >= FILL_AT) begin
				fill_table();
				filled = 1'b1;
			end else begin
				if (items_sent == PRESSURE_AT)
					long_hold = 1'b1;
				quiet = (items_sent >= ITEM_TARGET - QUIET_TAIL);
				mixed_item();
			end
		end
		req_valid <= 1'b0;

		while (tracker.pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (tracker.failures == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

`default_nettype wire
